### hdl/grid_astar_path_cost_macros.svh
// Assertion macros shared by the grid A* path cost RTL.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef GRID_ASTAR_PATH_COST_MACROS_SVH
`define GRID_ASTAR_PATH_COST_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define GAPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define GAPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/gapc_pkg.sv
// Package for the grid A* path cost block: opcodes, register indexes, mark codes.
// No dependencies; imported by the top level.
`default_nettype none

package gapc_pkg;

   // Input word operations.
   localparam logic OP_WRITE_CELL = 1'b0;
   localparam logic OP_SEARCH     = 1'b1;

   // Configuration register indexes.
   localparam int  CSR_INDEX_W     = 1;
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;
   localparam int  CSR_DATA_W      = 7;

   // Per-cell search marks.
   typedef logic [1:0] mark_type;
   localparam mark_type MARK_NONE   = 2'd0;
   localparam mark_type MARK_OPEN   = 2'd1;
   localparam mark_type MARK_CLOSED = 2'd2;

   // Result and arithmetic widths.
   localparam int COST_W  = 16;
   localparam int COUNT_W = 13;
   localparam int F_W     = 17;
   localparam logic [COST_W-1:0]  COST_MAX  = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

endpackage

`default_nettype wire

### hdl/grid_astar_path_cost.sv
// Top level of the grid A* path cost block: sequencer, scan unit and cell stores.
// Depends on gapc_pkg, gapc_ram and grid_astar_path_cost_macros.svh.
//
//   channel  direction  handshake              contents
//   req_     in         req_valid/req_ready    map cell write or search request
//   rsp_     out        rsp_valid/rsp_ready    found, path cost, expanded count
//   csr_     in         csr_write_enable       grid width and height
//
// A map write goes straight to the passable store. A search runs the start, target
// and end checks, a mark sweep over the W*H cells and a step to open the start,
// then per expanded cell a scan of the grid for the least f, a close step and up
// to 4 neighbour reads and updates, then posts the result (at once if off the grid).
// Synchronous active-high reset clears the sequencer and the output valid flag and sets the grid to 64 by 64.
// A finished result waits in the output register; map writes still proceed.
`default_nettype none

module grid_astar_path_cost
   import gapc_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int STEP_COST   = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_operation,
   input  wire [5:0]             req_cell_x,
   input  wire [5:0]             req_cell_y,
   input  wire                   req_passable,
   input  wire [5:0]             req_start_x,
   input  wire [5:0]             req_start_y,
   input  wire [5:0]             req_target_x,
   input  wire [5:0]             req_target_y,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_found,
   output logic [COST_W-1:0]     rsp_path_cost,
   output logic [COUNT_W-1:0]    rsp_expanded_count,
   input  wire                   csr_write_enable,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_write_data
);

`include "grid_astar_path_cost_macros.svh"

   localparam int XW    = $clog2(MAX_COLUMNS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK_S  = 4'd1;
   localparam logic [3:0] S_CHECK_T  = 4'd2;
   localparam logic [3:0] S_CHECK_E  = 4'd3;
   localparam logic [3:0] S_CLEAR    = 4'd4;
   localparam logic [3:0] S_INIT     = 4'd5;
   localparam logic [3:0] S_SCAN     = 4'd6;
   localparam logic [3:0] S_SCAN_END = 4'd7;
   localparam logic [3:0] S_PICK     = 4'd8;
   localparam logic [3:0] S_NB_ISSUE = 4'd9;
   localparam logic [3:0] S_NB_UPD   = 4'd10;
   localparam logic [3:0] S_FINISH   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [CSR_DATA_W-1:0] grid_width_ff, grid_width_in;
   logic [CSR_DATA_W-1:0] grid_height_ff, grid_height_in;
   logic [XW:0]           w_ff, w_in;
   logic [YW:0]           h_ff, h_in;
   logic [XW-1:0]         start_x_ff, start_x_in, target_x_ff, target_x_in;
   logic [YW-1:0]         start_y_ff, start_y_in, target_y_ff, target_y_in;
   logic                  start_pass_ff, start_pass_in;
   logic [XW-1:0]         cnt_x_ff, cnt_x_in;
   logic [YW-1:0]         cnt_y_ff, cnt_y_in;
   logic                  p_v_ff, p_v_in;
   logic [XW-1:0]         p_x_ff, p_x_in;
   logic [YW-1:0]         p_y_ff, p_y_in;
   logic                  any_ff, any_in;
   logic [F_W-1:0]        best_f_ff, best_f_in;
   logic [XW-1:0]         best_x_ff, best_x_in;
   logic [YW-1:0]         best_y_ff, best_y_in;
   logic [COST_W-1:0]     best_g_ff, best_g_in;
   logic [1:0]            dir_ff, dir_in;
   logic [XW-1:0]         nb_x_ff, nb_x_in;
   logic [YW-1:0]         nb_y_ff, nb_y_in;
   logic                  res_found_ff, res_found_in;
   logic [COST_W-1:0]     res_cost_ff, res_cost_in;
   logic [COUNT_W-1:0]    expanded_ff, expanded_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [COST_W-1:0]     rsp_cost_ff, rsp_cost_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic [XW:0]           w_sat;
   logic [YW:0]           h_sat;
   logic                  req_on_grid;
   logic                  cnt_last;
   logic [XW-1:0]         sel_x;
   logic [YW-1:0]         sel_y;
   logic [AW-1:0]         sel_cell;
   logic                  pass_we, pass_wd, pass_rd;
   logic                  mark_we;
   mark_type              mark_wd, mark_rd;
   logic                  cost_we;
   logic [COST_W-1:0]     cost_wd, cost_rd;
   logic [XW-1:0]         dist_x;
   logic [YW-1:0]         dist_y;
   logic [F_W-1:0]        f_val;
   logic [COST_W:0]       g_sum;
   logic [COST_W-1:0]     g_next;
   logic                  nb_ok;
   logic [XW-1:0]         nb_x_calc;
   logic [YW-1:0]         nb_y_calc;
   logic                  nb_take;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Grid size in use, saturated to the array size.
   assign w_sat = (32'(grid_width_ff) > MAX_COLUMNS) ? (XW+1)'(MAX_COLUMNS)
                                                     : (XW+1)'(grid_width_ff);
   assign h_sat = (32'(grid_height_ff) > MAX_ROWS) ? (YW+1)'(MAX_ROWS)
                                                   : (YW+1)'(grid_height_ff);
   assign req_on_grid = (32'(req_start_x) < 32'(w_sat)) && (32'(req_start_y) < 32'(h_sat))
                     && (32'(req_target_x) < 32'(w_sat)) && (32'(req_target_y) < 32'(h_sat));

   assign cnt_last = (cnt_x_ff == XW'(w_ff - 1'b1)) && (cnt_y_ff == YW'(h_ff - 1'b1));

   // Neighbour of the expanded cell in the current direction.
   always_comb begin
      nb_ok     = 1'b0;
      nb_x_calc = best_x_ff;
      nb_y_calc = best_y_ff;
      unique case (dir_ff)
         2'd0: begin
            nb_ok     = (best_x_ff != '0);
            nb_x_calc = best_x_ff - 1'b1;
         end
         2'd1: begin
            nb_ok     = (best_y_ff != '0);
            nb_y_calc = best_y_ff - 1'b1;
         end
         2'd2: begin
            nb_ok     = (({1'b0, best_y_ff} + 1'b1) < h_ff);
            nb_y_calc = best_y_ff + 1'b1;
         end
         default: begin
            nb_ok     = (({1'b0, best_x_ff} + 1'b1) < w_ff);
            nb_x_calc = best_x_ff + 1'b1;
         end
      endcase
   end

   // One shared cell address for all stores, chosen by the sequencer.
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            sel_x = XW'(req_cell_x);
            sel_y = YW'(req_cell_y);
         end
         S_CHECK_S, S_INIT: begin
            sel_x = start_x_ff;
            sel_y = start_y_ff;
         end
         S_CHECK_T: begin
            sel_x = target_x_ff;
            sel_y = target_y_ff;
         end
         S_PICK: begin
            sel_x = best_x_ff;
            sel_y = best_y_ff;
         end
         S_NB_ISSUE: begin
            sel_x = nb_x_calc;
            sel_y = nb_y_calc;
         end
         S_NB_UPD: begin
            sel_x = nb_x_ff;
            sel_y = nb_y_ff;
         end
         default: begin
            sel_x = cnt_x_ff;
            sel_y = cnt_y_ff;
         end
      endcase
   end

   assign sel_cell = AW'(32'(sel_y) * MAX_COLUMNS + 32'(sel_x));

   // Scan unit: f of the cell read last cycle.
   assign dist_x = (p_x_ff >= target_x_ff) ? (p_x_ff - target_x_ff) : (target_x_ff - p_x_ff);
   assign dist_y = (p_y_ff >= target_y_ff) ? (p_y_ff - target_y_ff) : (target_y_ff - p_y_ff);
   assign f_val  = F_W'(cost_rd) + F_W'(dist_x) + F_W'(dist_y);

   // Cost of a step from the expanded cell, saturating.
   assign g_sum  = (COST_W+1)'(best_g_ff) + (COST_W+1)'(STEP_COST);
   assign g_next = g_sum[COST_W] ? COST_MAX : g_sum[COST_W-1:0];

   // A neighbour is taken if it is passable and not closed.
   assign nb_take = pass_rd && (mark_rd != MARK_CLOSED);

   // Store write ports.
   assign pass_we = accept && (req_operation == OP_WRITE_CELL)
                 && (32'(req_cell_x) < MAX_COLUMNS) && (32'(req_cell_y) < MAX_ROWS);
   assign pass_wd = req_passable;

   always_comb begin
      mark_we = 1'b0;
      mark_wd = MARK_NONE;
      cost_we = 1'b0;
      cost_wd = g_next;
      unique case (state_ff)
         S_CLEAR: begin
            mark_we = 1'b1;
         end
         S_INIT: begin
            mark_we = 1'b1;
            mark_wd = MARK_OPEN;
            cost_we = 1'b1;
            cost_wd = '0;
         end
         S_PICK: begin
            mark_we = any_ff;
            mark_wd = MARK_CLOSED;
         end
         S_NB_UPD: begin
            mark_we = nb_take && (mark_rd != MARK_OPEN);
            mark_wd = MARK_OPEN;
            cost_we = nb_take && ((mark_rd != MARK_OPEN) || (g_next < cost_rd));
         end
         default: begin
            mark_we = 1'b0;
         end
      endcase
   end

   gapc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pass_ram (
      .clock   (clock),
      .wr_en   (pass_we),
      .wr_addr (sel_cell),
      .wr_data (pass_wd),
      .rd_addr (sel_cell),
      .rd_data (pass_rd)
   );

   gapc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (sel_cell),
      .wr_data (mark_wd),
      .rd_addr (sel_cell),
      .rd_data (mark_rd)
   );

   gapc_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (sel_cell),
      .wr_data (cost_wd),
      .rd_addr (sel_cell),
      .rd_data (cost_rd)
   );

   // Configuration registers.
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_write_data;
            CSR_GRID_HEIGHT: grid_height_in = csr_write_data;
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   // Search sequencer.
   always_comb begin
      state_in      = state_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      start_pass_in = start_pass_ff;
      cnt_x_in      = cnt_x_ff;
      cnt_y_in      = cnt_y_ff;
      p_v_in        = 1'b0;
      p_x_in        = p_x_ff;
      p_y_in        = p_y_ff;
      any_in        = any_ff;
      best_f_in     = best_f_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_g_in     = best_g_ff;
      dir_in        = dir_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      res_found_in  = res_found_ff;
      res_cost_in   = res_cost_ff;
      expanded_in   = expanded_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_count_in  = rsp_count_ff;

      // Walk the grid counters row by row.
      if ((state_ff == S_CLEAR) || (state_ff == S_SCAN)) begin
         if (cnt_x_ff == XW'(w_ff - 1'b1)) begin
            cnt_x_in = '0;
            cnt_y_in = cnt_y_ff + 1'b1;
         end else begin
            cnt_x_in = cnt_x_ff + 1'b1;
         end
      end

      // Keep the open cell of least f; ties go to the later cell.
      if (((state_ff == S_SCAN) || (state_ff == S_SCAN_END)) && p_v_ff
          && (mark_rd == MARK_OPEN) && (!any_ff || (f_val <= best_f_ff))) begin
         any_in    = 1'b1;
         best_f_in = f_val;
         best_x_in = p_x_ff;
         best_y_in = p_y_ff;
         best_g_in = cost_rd;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_operation == OP_SEARCH)) begin
               w_in         = w_sat;
               h_in         = h_sat;
               start_x_in   = XW'(req_start_x);
               start_y_in   = YW'(req_start_y);
               target_x_in  = XW'(req_target_x);
               target_y_in  = YW'(req_target_y);
               res_found_in = 1'b0;
               res_cost_in  = '0;
               expanded_in  = '0;
               state_in     = req_on_grid ? S_CHECK_S : S_FINISH;
            end
         end
         S_CHECK_S: begin
            state_in = S_CHECK_T;
         end
         S_CHECK_T: begin
            start_pass_in = pass_rd;
            state_in      = S_CHECK_E;
         end
         S_CHECK_E: begin
            cnt_x_in = '0;
            cnt_y_in = '0;
            state_in = (start_pass_ff && pass_rd) ? S_CLEAR : S_FINISH;
         end
         S_CLEAR: begin
            if (cnt_last) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cnt_x_in = '0;
            cnt_y_in = '0;
            any_in   = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            p_v_in = 1'b1;
            p_x_in = cnt_x_ff;
            p_y_in = cnt_y_ff;
            if (cnt_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (!any_ff) begin
               state_in = S_FINISH;
            end else begin
               if (expanded_ff != COUNT_MAX) begin
                  expanded_in = expanded_ff + 1'b1;
               end
               if ((best_x_ff == target_x_ff) && (best_y_ff == target_y_ff)) begin
                  res_found_in = 1'b1;
                  res_cost_in  = best_g_ff;
                  state_in     = S_FINISH;
               end else begin
                  dir_in   = '0;
                  state_in = S_NB_ISSUE;
               end
            end
         end
         S_NB_ISSUE: begin
            nb_x_in = nb_x_calc;
            nb_y_in = nb_y_calc;
            if (nb_ok) begin
               state_in = S_NB_UPD;
            end else if (dir_ff == 2'd3) begin
               cnt_x_in = '0;
               cnt_y_in = '0;
               any_in   = 1'b0;
               state_in = S_SCAN;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         S_NB_UPD: begin
            if (dir_ff == 2'd3) begin
               cnt_x_in = '0;
               cnt_y_in = '0;
               any_in   = 1'b0;
               state_in = S_SCAN;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = S_NB_ISSUE;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_cost_in  = res_cost_ff;
               rsp_count_in = expanded_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         grid_width_ff  <= CSR_DATA_W'(64);
         grid_height_ff <= CSR_DATA_W'(64);
         p_v_ff         <= 1'b0;
         any_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         p_v_ff         <= p_v_in;
         any_ff         <= any_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      h_ff          <= h_in;
      start_x_ff    <= start_x_in;
      start_y_ff    <= start_y_in;
      target_x_ff   <= target_x_in;
      target_y_ff   <= target_y_in;
      start_pass_ff <= start_pass_in;
      cnt_x_ff      <= cnt_x_in;
      cnt_y_ff      <= cnt_y_in;
      p_x_ff        <= p_x_in;
      p_y_ff        <= p_y_in;
      best_f_ff     <= best_f_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      best_g_ff     <= best_g_in;
      dir_ff        <= dir_in;
      nb_x_ff       <= nb_x_in;
      nb_y_ff       <= nb_y_in;
      res_found_ff  <= res_found_in;
      res_cost_ff   <= res_cost_in;
      expanded_ff   <= expanded_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_path_cost      = rsp_cost_ff;
   assign rsp_expanded_count = rsp_count_ff;

   // A found target has always been expanded at least once.
   `GAPC_ASSERT_NOW(a_found_has_count, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_count_ff != '0, "found result with no expanded cell")
   // Picking either finishes or moves on to the neighbours.
   `GAPC_ASSERT_NEXT(a_pick_next, clock, reset, state_ff == S_PICK, (state_ff == S_NB_ISSUE) || (state_ff == S_FINISH), "bad state after pick")
   // An accepted search leaves the idle state.
   `GAPC_ASSERT_NEXT(a_search_starts, clock, reset, accept && (req_operation == OP_SEARCH), state_ff != S_IDLE, "search did not start")
   // A neighbour update always follows its read.
   `GAPC_ASSERT_NOW(a_upd_after_issue, clock, reset, state_ff == S_NB_UPD, $past(state_ff) == S_NB_ISSUE, "neighbour update without read")

endmodule

`default_nettype wire

### hdl/gapc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced by the top level for every cell store.
`default_nettype none

module gapc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
